FILE: hw/rtl/cspg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cspg_pkg;

    // Field and register widths
    localparam int COORD_BITS        = 16;
    localparam int TENSION_FRAC_BITS = 8;
    localparam int TENS_W            = 10;
    localparam int SUB_W             = 5;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 10;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_TENSION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBDIV  = 1'b1;
    localparam logic [TENS_W-1:0]    TENSION_RST = TENS_W'(128);
    localparam logic [SUB_W-1:0]     SUBDIV_RST  = SUB_W'(8);

    // Datapath widths
    localparam int E_W  = ((TENS_W > TENSION_FRAC_BITS) ? TENS_W : TENSION_FRAC_BITS) + 4;
    localparam int PR_W = E_W + COORD_BITS;
    localparam int A_W  = PR_W + 2;
    localparam int C_W  = 3 * SUB_W;
    localparam int P2_W = A_W + C_W + 1;
    localparam int N_W  = P2_W + 2;
    localparam int D_W  = TENSION_FRAC_BITS + C_W;
    localparam int DCNT_W = $clog2(N_W + 1);

    localparam logic signed [E_W-1:0] ONE = E_W'(1) << TENSION_FRAC_BITS;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_PREP0,
        DP_PREP1,
        DP_MUL_E,
        DP_ADD_A,
        DP_MUL_C,
        DP_ADD_N,
        DP_DIV_GO,
        DP_STORE,
        DP_PUSH_SEG,
        DP_PUSH_END,
        DP_WIN_FILL,
        DP_WIN_SHIFT
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic             seg;
        logic             coord;
        logic [1:0]       k;
        logic [1:0]       i;
        logic [SUB_W-1:0] j;
        logic             eor;
    } t_dp_cmd;

    typedef struct packed {
        logic             div_done;
        logic             final_in;
        logic [SUB_W-1:0] subdiv;
    } t_dp_sts;

    // Cardinal basis entry (row k, column i), scaled by 2^TENSION_FRAC_BITS
    function automatic logic signed [E_W-1:0] cardinal_coef(
        input logic [1:0]        k,
        input logic [1:0]        i,
        input logic [TENS_W-1:0] t_in
    );
        logic signed [E_W-1:0] t;
        logic signed [E_W-1:0] e;
        t = $signed(E_W'(t_in));
        unique case ({k, i})
            4'h0:    e = -t;
            4'h1:    e = (ONE <<< 1) - t;
            4'h2:    e = t - (ONE <<< 1);
            4'h3:    e = t;
            4'h4:    e = t <<< 1;
            4'h5:    e = t - (ONE + (ONE <<< 1));
            4'h6:    e = (ONE + (ONE <<< 1)) - (t <<< 1);
            4'h7:    e = -t;
            4'h8:    e = -t;
            4'hA:    e = t;
            4'hD:    e = ONE;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cspg_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cspg_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cspg_pkg::COORD_BITS-1:0] point_x;
    logic signed [cspg_pkg::COORD_BITS-1:0] point_y;
    logic                                   final_point;

    modport source (output valid, output point_x, output point_y, output final_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input final_point,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cspg_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cspg_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cspg_pkg::COORD_BITS-1:0] curve_x;
    logic signed [cspg_pkg::COORD_BITS-1:0] curve_y;
    logic                                   end_of_run;
    logic                                   end_of_curve;

    modport source (output valid, output curve_x, output curve_y, output end_of_run,
                    output end_of_curve, input ready);
    modport sink   (input valid, input curve_x, input curve_y, input end_of_run,
                    input end_of_curve, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cardinal_spline_point_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Cardinal spline point generator.
// Control points enter on i_pts (valid/ready), one beat per point; final_point
// marks the last point of a curve. Curve points leave on o_crv, one beat each;
// end_of_run marks the last beat caused by an input point, end_of_curve the
// closing endpoint. Tension and subdivisions are written through the plain
// write port (index 0 tension, index 1 subdivisions); the user must write
// them only while the block is idle; nothing in the block enforces this.
// One point is worked on at a time: i_pts.ready is high only when the
// sequencer is idle. Each curve point is built by a multiply-add sequence
// and a one-bit-a-cycle divider for each coordinate. The last beat sits in
// an output register, so the next input point is taken while it waits. When
// o_crv.ready is low the sequencer finishes the next curve point and holds
// until the register frees.
// Reset restores tension 128, subdivisions 8 and an empty point window.
module cardinal_spline_point_generator_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [cspg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [cspg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    cspg_in_if.sink                                 i_pts,
    cspg_out_if.source                              o_crv
);
    import cspg_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    cspg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pts.valid),
        .o_in_ready  (i_pts.ready),
        .o_out_valid (o_crv.valid),
        .i_out_ready (o_crv.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    cspg_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_point_x      (i_pts.point_x),
        .i_point_y      (i_pts.point_y),
        .i_final_point  (i_pts.final_point),
        .o_curve_x      (o_crv.curve_x),
        .o_curve_y      (o_crv.curve_y),
        .o_end_of_run   (o_crv.end_of_run),
        .o_end_of_curve (o_crv.end_of_curve)
    );

    // An accepted beat closes the input until the point is handled
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pts.valid && i_pts.ready) |=> !i_pts.ready)
        else $error("input still open after accepting a point");

    // The divider never finishes in the cycle after it starts
    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == DP_DIV_GO) |=> !w_sts.div_done)
        else $error("divider done too early");

    // The closing endpoint is always the last beat of its run
    a_end_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_crv.valid && o_crv.end_of_curve) |-> o_crv.end_of_run)
        else $error("end of curve without end of run");

endmodule

`default_nettype wire

FILE: hw/rtl/cspg_div.sv
`timescale 1ns / 1ps
`default_nettype none

module cspg_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [cspg_pkg::N_W-1:0]      i_dividend,
    input  wire logic [cspg_pkg::D_W-1:0]      i_divisor,
    output logic      [cspg_pkg::N_W-1:0]      o_quotient,
    output logic                               o_done
);
    import cspg_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [D_W-1:0]    r_rem;
    logic [N_W-1:0]    r_quo;
    logic [D_W-1:0]    r_div;

    logic [D_W:0] w_rem_sh;
    logic [D_W:0] w_diff;
    logic         w_ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_rem_sh = {r_rem, r_quo[N_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_div};
        w_ge     = (w_rem_sh >= {1'b0, r_div});
    end

    // Control: count the steps, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(N_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - DCNT_W'(1);
                end
            end
        end
    end

    // Data: partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_rem_sh[D_W-1:0];
            r_quo <= {r_quo[N_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

FILE: hw/rtl/cspg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cspg_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire cspg_pkg::t_dp_cmd                     i_cmd,
    output cspg_pkg::t_dp_sts                          o_sts,
    input  wire logic                                  i_cfg_we,
    input  wire logic [cspg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [cspg_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic signed [cspg_pkg::COORD_BITS-1:0] i_point_x,
    input  wire logic signed [cspg_pkg::COORD_BITS-1:0] i_point_y,
    input  wire logic                                  i_final_point,
    output logic signed [cspg_pkg::COORD_BITS-1:0]     o_curve_x,
    output logic signed [cspg_pkg::COORD_BITS-1:0]     o_curve_y,
    output logic                                       o_end_of_run,
    output logic                                       o_end_of_curve
);
    import cspg_pkg::*;

    localparam logic [N_W-1:0] POS_MAX = {{(N_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic [N_W-1:0] NEG_MAG = POS_MAX + N_W'(1);

    // Configuration
    logic [TENS_W-1:0] r_tension;
    logic [SUB_W-1:0]  r_subdiv;

    // Window and captured point
    logic signed [COORD_BITS-1:0] r_wx [3];
    logic signed [COORD_BITS-1:0] r_wy [3];
    logic signed [COORD_BITS-1:0] r_ix;
    logic signed [COORD_BITS-1:0] r_iy;
    logic                         r_ifin;

    // Arithmetic
    logic [2*SUB_W-1:0]       r_jj;
    logic [2*SUB_W-1:0]       r_gg;
    logic [C_W-1:0]           r_c [4];
    logic signed [PR_W-1:0]   r_prod;
    logic signed [A_W-1:0]    r_a;
    logic signed [P2_W-1:0]   r_prod2;
    logic signed [N_W-1:0]    r_n;
    logic                     r_neg;
    logic signed [COORD_BITS-1:0] r_res_x;
    logic signed [COORD_BITS-1:0] r_res_y;

    // Output beat
    logic signed [COORD_BITS-1:0] r_ox;
    logic signed [COORD_BITS-1:0] r_oy;
    logic                         r_oeor;
    logic                         r_oeoc;

    logic signed [COORD_BITS-1:0] w_p;
    logic signed [E_W-1:0]        w_coef;
    logic [N_W-1:0]               w_mag;
    logic [N_W-1:0]               w_quo;
    logic                         w_div_done;
    logic signed [COORD_BITS-1:0] w_sat;
    logic [COORD_BITS-1:0]        w_negq;

    // Select the control point for this segment and coordinate
    always_comb begin
        logic signed [COORD_BITS-1:0] w0, w1, w2, pin;
        w0  = i_cmd.coord ? r_wy[0] : r_wx[0];
        w1  = i_cmd.coord ? r_wy[1] : r_wx[1];
        w2  = i_cmd.coord ? r_wy[2] : r_wx[2];
        pin = i_cmd.coord ? r_iy : r_ix;
        case ({i_cmd.seg, i_cmd.i})
            3'b000:  w_p = w0;
            3'b001:  w_p = w1;
            3'b010:  w_p = w2;
            3'b011:  w_p = pin;
            3'b100:  w_p = w1;
            3'b101:  w_p = w2;
            default: w_p = pin;
        endcase
    end

    assign w_coef = cardinal_coef(i_cmd.k, i_cmd.i, r_tension);
    assign w_mag  = r_n[N_W-1] ? N_W'(-r_n) : N_W'(r_n);

    cspg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == DP_DIV_GO),
        .i_dividend (w_mag),
        .i_divisor  ({r_c[3], {TENSION_FRAC_BITS{1'b0}}}),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // Apply the sign and clamp to the coordinate range
    always_comb begin
        w_negq = COORD_BITS'(-w_quo);
        if (r_neg) begin
            w_sat = (w_quo > NEG_MAG) ? $signed({1'b1, {(COORD_BITS-1){1'b0}}})
                                      : $signed(w_negq);
        end else begin
            w_sat = (w_quo > POS_MAX) ? $signed({1'b0, {(COORD_BITS-1){1'b1}}})
                                      : $signed(w_quo[COORD_BITS-1:0]);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension <= TENSION_RST;
            r_subdiv  <= SUBDIV_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TENSION: r_tension <= i_cfg_data[TENS_W-1:0];
                CFG_SUBDIV:  r_subdiv  <= i_cfg_data[SUB_W-1:0];
                default:     ;
            endcase
        end
    end

    // Window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wx <= '{default: '0};
            r_wy <= '{default: '0};
        end else if (i_cmd.op == DP_WIN_FILL) begin
            r_wx <= '{r_ix, r_ix, r_ix};
            r_wy <= '{r_iy, r_iy, r_iy};
        end else if (i_cmd.op == DP_WIN_SHIFT) begin
            r_wx <= '{r_wx[1], r_wx[2], r_ix};
            r_wy <= '{r_wy[1], r_wy[2], r_iy};
        end
    end

    // Arithmetic sequence, one step per command
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_CAPTURE: begin
                r_ix   <= i_point_x;
                r_iy   <= i_point_y;
                r_ifin <= i_final_point;
            end
            DP_PREP0: begin
                r_jj <= i_cmd.j * i_cmd.j;
                r_gg <= r_subdiv * r_subdiv;
                r_a  <= '0;
                r_n  <= '0;
            end
            DP_PREP1: begin
                r_c[0] <= C_W'(r_jj) * C_W'(i_cmd.j);
                r_c[1] <= C_W'(r_jj) * C_W'(r_subdiv);
                r_c[2] <= C_W'(r_gg) * C_W'(i_cmd.j);
                r_c[3] <= C_W'(r_gg) * C_W'(r_subdiv);
            end
            DP_MUL_E:  r_prod <= w_coef * w_p;
            DP_ADD_A:  r_a    <= r_a + A_W'(r_prod);
            DP_MUL_C: begin
                r_prod2 <= r_a * $signed({1'b0, r_c[i_cmd.k]});
                r_a     <= '0;
            end
            DP_ADD_N:  r_n <= r_n + N_W'(r_prod2);
            DP_DIV_GO: begin
                r_neg <= r_n[N_W-1];
                r_n   <= '0;
            end
            DP_STORE: begin
                if (i_cmd.coord) begin
                    r_res_y <= w_sat;
                end else begin
                    r_res_x <= w_sat;
                end
            end
            DP_PUSH_SEG: begin
                r_ox   <= r_res_x;
                r_oy   <= r_res_y;
                r_oeor <= i_cmd.eor;
                r_oeoc <= 1'b0;
            end
            DP_PUSH_END: begin
                r_ox   <= r_ix;
                r_oy   <= r_iy;
                r_oeor <= 1'b1;
                r_oeoc <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.final_in = r_ifin;
    assign o_sts.subdiv   = r_subdiv;

    assign o_curve_x      = r_ox;
    assign o_curve_y      = r_oy;
    assign o_end_of_run   = r_oeor;
    assign o_end_of_curve = r_oeoc;

endmodule

`default_nettype wire

FILE: hw/rtl/cspg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cspg_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output cspg_pkg::t_dp_cmd         o_cmd,
    input  wire cspg_pkg::t_dp_sts    i_sts
);
    import cspg_pkg::*;

    localparam logic [3:0] M_MUL_C = 4'd8;
    localparam logic [3:0] M_ADD_N = 4'd9;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SEG,
        S_PREP0,
        S_PREP1,
        S_MAC,
        S_DIVGO,
        S_DIVWAIT,
        S_PUSH,
        S_END,
        S_WIN
    } t_state;

    t_state           r_state;
    logic             r_seg;
    logic             r_coord;
    logic [1:0]       r_k;
    logic [3:0]       r_m;
    logic [SUB_W-1:0] r_j;
    logic [1:0]       r_seen;
    logic             r_out_vld;

    logic w_space;
    logic w_last_j;
    logic w_emit;

    assign w_space  = !r_out_vld || i_out_ready;
    assign w_last_j = (r_j == i_sts.subdiv - SUB_W'(1));
    assign w_emit   = w_space && ((r_state == S_PUSH) || (r_state == S_END));

    // Commands to the datapath
    always_comb begin
        o_cmd.op    = DP_NOP;
        o_cmd.seg   = r_seg;
        o_cmd.coord = r_coord;
        o_cmd.k     = r_k;
        o_cmd.i     = r_m[2:1];
        o_cmd.j     = r_j;
        o_cmd.eor   = !r_seg && !i_sts.final_in && w_last_j;
        unique case (r_state)
            S_IDLE:    o_cmd.op = (i_in_valid) ? DP_CAPTURE : DP_NOP;
            S_PREP0:   o_cmd.op = DP_PREP0;
            S_PREP1:   o_cmd.op = DP_PREP1;
            S_MAC: begin
                case (r_m)
                    M_MUL_C: o_cmd.op = DP_MUL_C;
                    M_ADD_N: o_cmd.op = DP_ADD_N;
                    default: o_cmd.op = r_m[0] ? DP_ADD_A : DP_MUL_E;
                endcase
            end
            S_DIVGO:   o_cmd.op = DP_DIV_GO;
            S_DIVWAIT: o_cmd.op = i_sts.div_done ? DP_STORE : DP_NOP;
            S_PUSH:    o_cmd.op = w_space ? DP_PUSH_SEG : DP_NOP;
            S_END:     o_cmd.op = w_space ? DP_PUSH_END : DP_NOP;
            S_WIN:     o_cmd.op = (r_seen == 2'd0) ? DP_WIN_FILL : DP_WIN_SHIFT;
            default:   o_cmd.op = DP_NOP;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seg     <= 1'b0;
            r_coord   <= 1'b0;
            r_k       <= '0;
            r_m       <= '0;
            r_j       <= '0;
            r_seen    <= 2'd0;
            r_out_vld <= 1'b0;
        end else begin
            // Raise the output beat on a push, drop it once taken
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_seen == 2'd2) begin
                        r_seg   <= 1'b0;
                        r_state <= S_SEG;
                    end else if (i_sts.final_in) begin
                        if (r_seen == 2'd1) begin
                            r_seg   <= 1'b1;
                            r_state <= S_SEG;
                        end else begin
                            r_state <= S_END;
                        end
                    end else begin
                        r_state <= S_WIN;
                    end
                end
                S_SEG: begin
                    r_j <= '0;
                    if (i_sts.subdiv == '0) begin
                        if (r_seg) begin
                            r_state <= S_END;
                        end else if (i_sts.final_in) begin
                            r_seg <= 1'b1;
                        end else begin
                            r_state <= S_WIN;
                        end
                    end else begin
                        r_state <= S_PREP0;
                    end
                end
                S_PREP0: r_state <= S_PREP1;
                S_PREP1: begin
                    r_coord <= 1'b0;
                    r_k     <= '0;
                    r_m     <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (r_m == M_ADD_N) begin
                        r_m <= '0;
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            r_state <= S_DIVGO;
                        end
                    end else begin
                        r_m <= r_m + 4'd1;
                    end
                end
                S_DIVGO: r_state <= S_DIVWAIT;
                S_DIVWAIT: begin
                    if (i_sts.div_done) begin
                        if (r_coord) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_coord <= 1'b1;
                            r_k     <= '0;
                            r_m     <= '0;
                            r_state <= S_MAC;
                        end
                    end
                end
                S_PUSH: begin
                    if (w_space) begin
                        if (!w_last_j) begin
                            r_j     <= r_j + SUB_W'(1);
                            r_state <= S_PREP0;
                        end else if (r_seg) begin
                            r_state <= S_END;
                        end else if (i_sts.final_in) begin
                            r_seg   <= 1'b1;
                            r_state <= S_SEG;
                        end else begin
                            r_state <= S_WIN;
                        end
                    end
                end
                S_END: begin
                    if (w_space) begin
                        r_seen  <= 2'd0;
                        r_state <= S_IDLE;
                    end
                end
                S_WIN: begin
                    r_seen  <= (r_seen == 2'd0) ? 2'd1 : 2'd2;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

FILE: tb/cardinal_spline_point_generator_core_test.sv
`timescale 1ns / 1ps

module cardinal_spline_point_generator_core_test;
    import cspg_pkg::*;

    localparam int ONE_Q     = 1 << TENSION_FRAC_BITS;
    localparam int IDLE_PCT  = 36;
    localparam int HOLD_LONG = 4000;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   eor;
        logic   eoc;
    } t_curve_beat;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cspg_in_if  pts ();
    cspg_out_if crv ();

    cardinal_spline_point_generator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pts       (pts.sink),
        .o_crv       (crv.source)
    );

    // Shadow configuration and point window
    longint tension_sh;
    longint subdiv_sh;
    longint win_x [3];
    longint win_y [3];
    int     pts_seen;

    t_curve_beat expected_beats [$];

    int  errors;
    int  points_sent;
    int  curves_sent;
    int  beats_checked;
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  hold_req;
    bit  hold_seen;
    int  hold_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #250_000_000;
        $display("timeout: %0d beats still expected", expected_beats.size());
        $display("** cardinal_spline_point_generator_core: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Exact polynomial value of one coordinate, truncated toward zero and saturated
    function automatic t_coord curve_coord(input longint p0, input longint p1,
                                           input longint p2, input longint p3,
                                           input longint j);
        longint t, g, r0, r1, r2, r3, num, den, q;
        t   = tension_sh;
        g   = subdiv_sh;
        r0  = -t * p0 + (2 * ONE_Q - t) * p1 + (t - 2 * ONE_Q) * p2 + t * p3;
        r1  = 2 * t * p0 + (t - 3 * ONE_Q) * p1 + (3 * ONE_Q - 2 * t) * p2 - t * p3;
        r2  = -t * p0 + t * p2;
        r3  = ONE_Q * p1;
        num = r0 * j * j * j + r1 * j * j * g + r2 * j * g * g + r3 * g * g * g;
        den = ONE_Q * g * g * g;
        q   = num / den;
        if (q > 32767)  q = 32767;
        if (q < -32768) q = -32768;
        return t_coord'(q);
    endfunction

    task automatic push_segment(input longint ax[4], input longint ay[4], inout int n);
        t_curve_beat b;
        for (longint j = 0; j < subdiv_sh; j++) begin
            b.x   = curve_coord(ax[0], ax[1], ax[2], ax[3], j);
            b.y   = curve_coord(ay[0], ay[1], ay[2], ay[3], j);
            b.eor = 1'b0;
            b.eoc = 1'b0;
            expected_beats.insert(expected_beats.size(), b);
            n++;
        end
    endtask

    // Advance the window for one accepted point and queue the curve beats it causes
    task automatic predict_curve_beats(input t_coord x, input t_coord y, input logic fin);
        longint ax [4];
        longint ay [4];
        t_curve_beat b;
        int n;
        n = 0;
        if (pts_seen == 2) begin
            ax = '{win_x[0], win_x[1], win_x[2], longint'(x)};
            ay = '{win_y[0], win_y[1], win_y[2], longint'(y)};
            push_segment(ax, ay, n);
        end
        if (fin) begin
            if (pts_seen >= 1) begin
                ax = '{win_x[1], win_x[2], longint'(x), longint'(x)};
                ay = '{win_y[1], win_y[2], longint'(y), longint'(y)};
                push_segment(ax, ay, n);
            end
            b.x = x; b.y = y; b.eor = 1'b0; b.eoc = 1'b1;
            expected_beats.insert(expected_beats.size(), b);
            n++;
            pts_seen = 0;
            curves_sent++;
        end else if (pts_seen == 0) begin
            win_x = '{x, x, x};
            win_y = '{y, y, y};
            pts_seen = 1;
        end else begin
            win_x = '{win_x[1], win_x[2], longint'(x)};
            win_y = '{win_y[1], win_y[2], longint'(y)};
            pts_seen = 2;
        end
        if (n > 0) expected_beats[$].eor = 1'b1;
    endtask

    // Send one control point; valid stays high into the next call unless idling
    task automatic send_point(input t_coord x, input t_coord y, input logic fin);
        if (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            pts.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge i_clk);
        end
        pts.valid       <= 1'b1;
        pts.point_x     <= x;
        pts.point_y     <= y;
        pts.final_point <= fin;
        @(posedge i_clk);
        while (!pts.ready) @(posedge i_clk);
        predict_curve_beats(x, y, fin);
        points_sent++;
    endtask

    // Drop valid and wait until every expected beat is out and the block settles
    task automatic drain;
        pts.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_config(input longint tens, input longint sub);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TENSION;
        i_cfg_data  <= CFG_DATA_W'(tens);
        @(posedge i_clk);
        i_cfg_index <= CFG_SUBDIV;
        i_cfg_data  <= CFG_DATA_W'(sub);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tension_sh = tens & 10'h3FF;
        subdiv_sh  = sub & 5'h1F;
    endtask

    function automatic t_coord rand_coord;
        case ($urandom_range(9))
            0:       return t_coord'(-32768);
            1:       return t_coord'(32767);
            2:       return t_coord'($urandom_range(0, 64) - 32);
            default: return t_coord'($urandom);
        endcase
    endfunction

    task automatic send_curve(input int len);
        for (int k = 0; k < len; k++)
            send_point(rand_coord(), rand_coord(), k == len - 1);
    endtask

    // Receiver: check each beat, then pick ready for the next cycle
    always @(posedge i_clk) begin
        t_curve_beat w;
        if (!i_rst_n) begin
            crv.ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (crv.valid && crv.ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("beat count", beats_checked + 1, beats_checked);
                end else begin
                    w = expected_beats.pop_front();
                    if (crv.curve_x !== w.x)
                        report_mismatch("curve_x", crv.curve_x, w.x);
                    if (crv.curve_y !== w.y)
                        report_mismatch("curve_y", crv.curve_y, w.y);
                    if (crv.end_of_run !== w.eor)
                        report_mismatch("end_of_run", crv.end_of_run, w.eor);
                    if (crv.end_of_curve !== w.eoc)
                        report_mismatch("end_of_curve", crv.end_of_curve, w.eoc);
                    beats_checked++;
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_LONG;
                crv.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                crv.ready <= 1'b0;
            end else begin
                crv.ready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Edges of the fields and the short-curve cases at reset settings
    task automatic test_directed;
        send_point(16'sh7FFF, -16'sh8000, 1'b1);
        send_point(-16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, -16'sh8000, 1'b1);
        send_point(100, -200, 1'b0);
        send_point(-300, 400, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_point(-16'sh8000, -16'sh8000, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(-16'sh8000, -16'sh8000, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(0, 0, 1'b1);
        drain();
    endtask

    // Extreme and out-of-range settings, including zero and maximum subdivisions
    task automatic test_config_extremes;
        write_config(0, 1);
        send_curve(4);
        send_point(-16'sh8000, 16'sh7FFF, 1'b1);
        drain();
        write_config(512, 31);
        send_curve(3);
        drain();
        write_config(1023, 3);
        send_point(-16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, -16'sh8000, 1'b0);
        send_point(-16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, -16'sh8000, 1'b1);
        drain();
        write_config(300, 0);
        send_curve(1);
        send_curve(2);
        send_curve(5);
        drain();
    endtask

    // Hold the receiver off while points keep coming, so the input stalls
    task automatic test_backpressure;
        write_config(200, 4);
        pts.valid <= 1'b0;
        @(posedge i_clk);
        hold_req <= ~hold_req;
        send_curve(6);
        drain();
    endtask

    // Random curves over a run of settings, with a stretch of no idling
    task automatic test_random_curves;
        int stop_at;
        stop_at = points_sent + 272;
        while (points_sent < stop_at) begin
            case ($urandom_range(5))
                0:       write_config($urandom_range(0, 1023), $urandom_range(1, 4));
                1:       write_config(512 * $urandom_range(0, 1), $urandom_range(0, 6));
                2:       write_config($urandom_range(0, 1023), $urandom_range(8, 12));
                default: write_config($urandom_range(0, 512), $urandom_range(1, 3));
            endcase
            if (points_sent > stop_at - 100 && points_sent < stop_at - 60) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
            repeat ($urandom_range(3, 7))
                send_curve($urandom_range(0, 3) == 0 ? $urandom_range(1, 2)
                                                     : $urandom_range(3, 8));
            drain();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        errors        = 0;
        points_sent   = 0;
        curves_sent   = 0;
        beats_checked = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_req      = 1'b0;
        hold_seen     = 1'b0;
        tension_sh    = 128;
        subdiv_sh     = 8;
        win_x         = '{0, 0, 0};
        win_y         = '{0, 0, 0};
        pts_seen      = 0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_TENSION;
        i_cfg_data      <= '0;
        pts.valid       <= 1'b0;
        pts.point_x     <= '0;
        pts.point_y     <= '0;
        pts.final_point <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_curves();

        drain();
        repeat (400) @(posedge i_clk);
        $display("covered %0d control points in %0d curves, %0d curve beats checked,",
                 points_sent, curves_sent, beats_checked);
        $display("tension 0..1023, subdivisions 0..31, long output stall");
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("** cardinal_spline_point_generator_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d beats missing", errors, expected_beats.size());
            $display("** cardinal_spline_point_generator_core: FAILED **");
        end
        $finish;
    end

endmodule
